/* sv/assert_macros.svh */
// Assertion macros shared by the checker files.
// No dependencies; the including scope must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, muted while reset is active.
`define SMDR_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every rising edge, reset included.
`define SMDR_ASSERT_ALL(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/smdr_pkg.sv */
// Types and constants of the switch mask debounce reporter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package smdr_pkg;

    localparam int MASK_W  = 8;
    localparam int CNT_W   = 16;
    localparam int BYTE_W  = 4;
    localparam int IDX_W   = 2;
    localparam int CFG_W   = 16;

    localparam logic [CNT_W-1:0] CNT_MAX         = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] DEBOUNCE_RESET  = 16'd20;
    localparam logic [CNT_W-1:0] HEARTBEAT_RESET = 16'd20;

    localparam logic [IDX_W-1:0] REG_DEBOUNCE  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEARTBEAT = 2'd1;

    typedef struct packed {
        logic [CNT_W-1:0] debounce_ticks;
        logic [CNT_W-1:0] heartbeat_ticks;
    } cfg_t;

    typedef struct packed {
        logic              send_frame;
        logic [MASK_W-1:0] pressed_mask;
        logic [MASK_W-1:0] stable_mask;
    } result_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

    function automatic logic [BYTE_W-1:0] payload_byte(input logic active,
                                                       input int unsigned k);
        return active ? BYTE_W'(k + 2) : '0;
    endfunction

endpackage

/* sv/switch_mask_debounce_reporter_top.sv */
// Top level of the switch mask debounce reporter: config registers,
// result register and handshake. Depends on smdr_pkg and smdr_core.
//
//   channel | direction | handshake            | payload
//   input   | in        | in_valid / in_stall   | pin_levels
//   result  | out       | out_valid / out_stall | send_frame, pressed_mask,
//           |           |                       | stable_mask, byte0..byte7
//   config  | in        | cfg_we                | cfg_index, cfg_wdata
//
// One item per cycle while in_stall is low; its result appears in the cycle after it is accepted.
// The result register sets the timing: a new item enters whenever the
// register is empty or is emptied in the same cycle.
// in_stall is high only while a result waits under out_stall.
// Reset clears the debounce state and counters and loads 20 into both
// config registers.
`timescale 1ns / 1ps

module switch_mask_debounce_reporter_top #(
    parameter int NUM_SWITCHES = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [smdr_pkg::MASK_W-1:0]   pin_levels,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          send_frame,
    output logic [smdr_pkg::MASK_W-1:0]   pressed_mask,
    output logic [smdr_pkg::MASK_W-1:0]   stable_mask,
    output logic [smdr_pkg::BYTE_W-1:0]   byte0,
    output logic [smdr_pkg::BYTE_W-1:0]   byte1,
    output logic [smdr_pkg::BYTE_W-1:0]   byte2,
    output logic [smdr_pkg::BYTE_W-1:0]   byte3,
    output logic [smdr_pkg::BYTE_W-1:0]   byte4,
    output logic [smdr_pkg::BYTE_W-1:0]   byte5,
    output logic [smdr_pkg::BYTE_W-1:0]   byte6,
    output logic [smdr_pkg::BYTE_W-1:0]   byte7,
    input  logic                          cfg_we,
    input  logic [smdr_pkg::IDX_W-1:0]    cfg_index,
    input  logic [smdr_pkg::CFG_W-1:0]    cfg_wdata
);
    import smdr_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    result_t res_reg;
    result_t core_res;
    logic    out_valid_reg, out_valid_next;
    logic    in_fire;

    assign in_stall = out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;

    smdr_core #(
        .NUM_SWITCHES(NUM_SWITCHES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (in_fire),
        .pin_levels (pin_levels),
        .cfg        (cfg_reg),
        .result     (core_res)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE:  cfg_next.debounce_ticks  = cfg_wdata;
                REG_HEARTBEAT: cfg_next.heartbeat_ticks = cfg_wdata;
                default:       cfg_next = cfg_reg;
            endcase
        end
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks  <= DEBOUNCE_RESET;
            cfg_reg.heartbeat_ticks <= HEARTBEAT_RESET;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_reg <= core_res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign send_frame   = res_reg.send_frame;
    assign pressed_mask = res_reg.pressed_mask;
    assign stable_mask  = res_reg.stable_mask;
    assign byte0 = payload_byte(res_reg.stable_mask[0], 0);
    assign byte1 = payload_byte(res_reg.stable_mask[1], 1);
    assign byte2 = payload_byte(res_reg.stable_mask[2], 2);
    assign byte3 = payload_byte(res_reg.stable_mask[3], 3);
    assign byte4 = payload_byte(res_reg.stable_mask[4], 4);
    assign byte5 = payload_byte(res_reg.stable_mask[5], 5);
    assign byte6 = payload_byte(res_reg.stable_mask[6], 6);
    assign byte7 = payload_byte(res_reg.stable_mask[7], 7);

endmodule

/* sv/smdr_core.sv */
// Debounce state and per-tick result logic of the switch mask reporter.
// Depends on smdr_pkg.
`timescale 1ns / 1ps

module smdr_core #(
    parameter int NUM_SWITCHES = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [smdr_pkg::MASK_W-1:0]   pin_levels,
    input  smdr_pkg::cfg_t                cfg,
    output smdr_pkg::result_t             result
);
    import smdr_pkg::*;

    localparam logic [MASK_W-1:0] SW_MASK =
        MASK_W'((9'(1) << NUM_SWITCHES) - 9'(1));

    logic [MASK_W-1:0] prev_raw_reg, prev_raw_next;
    logic [MASK_W-1:0] debounced_reg, debounced_next;
    logic [CNT_W-1:0]  since_change_reg, since_change_next;
    logic [CNT_W-1:0]  since_send_reg, since_send_next;
    logic [MASK_W-1:0] raw;
    logic [CNT_W-1:0]  since_send_inc;
    logic              send;

    always_comb
    begin
        raw           = ~pin_levels & SW_MASK;
        prev_raw_next = raw;
        if (raw != prev_raw_reg)
        begin
            since_change_next = '0;
        end
        else
        begin
            since_change_next = sat_inc(since_change_reg);
        end
        debounced_next = (since_change_next > cfg.debounce_ticks) ? raw : debounced_reg;
        since_send_inc = sat_inc(since_send_reg);
        send = (debounced_next != debounced_reg) ||
               (since_send_inc >= cfg.heartbeat_ticks);
        since_send_next = send ? '0 : since_send_inc;

        result.send_frame   = send;
        result.pressed_mask = debounced_next & ~debounced_reg;
        result.stable_mask  = debounced_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg     <= '0;
            debounced_reg    <= '0;
            since_change_reg <= '0;
            since_send_reg   <= '0;
        end
        else if (step)
        begin
            prev_raw_reg     <= prev_raw_next;
            debounced_reg    <= debounced_next;
            since_change_reg <= since_change_next;
            since_send_reg   <= since_send_next;
        end
    end

endmodule

/* sv/smdr_checker.sv */
// Port-level checks of the switch mask debounce reporter, bound to the top.
// Depends on smdr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smdr_port_props (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          send_frame,
    input logic [smdr_pkg::MASK_W-1:0]   pressed_mask,
    input logic [smdr_pkg::MASK_W-1:0]   stable_mask,
    input logic [smdr_pkg::BYTE_W-1:0]   byte0
);

    `SMDR_ASSERT_ALL(a_no_result_in_reset, !rst_n |-> !out_valid, "result valid during reset")

    `SMDR_ASSERT_RST(a_accept_loads, in_valid && !in_stall |=> out_valid, "accepted item lost")

    `SMDR_ASSERT_RST(a_hold_stalled, out_valid && out_stall |=> out_valid && $stable(stable_mask) && $stable(send_frame), "stalled result changed")

    `SMDR_ASSERT_RST(a_pressed_stable, out_valid |-> ((pressed_mask & ~stable_mask) == '0) && (pressed_mask == '0 || send_frame), "pressed switch not sent")

    `SMDR_ASSERT_RST(a_payload0, out_valid |-> byte0 == (stable_mask[0] ? 4'd2 : 4'd0), "payload byte 0 wrong")

endmodule

bind switch_mask_debounce_reporter_top smdr_port_props u_smdr_port_props (.*);

/* verif/smdr_checker.sv */
// Scoreboard for the switch mask debounce reporter: tracks config writes,
// predicts one report per accepted sample and compares it with the block's output.
// Depends on smdr_pkg; instantiated beside the block by tb_top.
`timescale 1ns / 1ps

module smdr_checker
    import smdr_pkg::*;
#(
    parameter int MAX_REPORTS = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [MASK_W-1:0]              pin_levels,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic                           send_frame,
    input  logic [MASK_W-1:0]              pressed_mask,
    input  logic [MASK_W-1:0]              stable_mask,
    input  logic [BYTE_W-1:0]              byte0,
    input  logic [BYTE_W-1:0]              byte1,
    input  logic [BYTE_W-1:0]              byte2,
    input  logic [BYTE_W-1:0]              byte3,
    input  logic [BYTE_W-1:0]              byte4,
    input  logic [BYTE_W-1:0]              byte5,
    input  logic [BYTE_W-1:0]              byte6,
    input  logic [BYTE_W-1:0]              byte7,
    input  logic                           cfg_we,
    input  logic [IDX_W-1:0]               cfg_index,
    input  logic [CFG_W-1:0]               cfg_wdata,
    output int                             fail_count,
    output int                             pending_count
);

    typedef struct packed {
        logic                          send;
        logic [MASK_W-1:0]             pressed;
        logic [MASK_W-1:0]             stable;
        logic [MASK_W-1:0][BYTE_W-1:0] payload;
    } tick_report_t;

    cfg_t              cfg;
    logic [MASK_W-1:0] last_active;
    logic [MASK_W-1:0] stable_now;
    logic [CNT_W-1:0]  change_ticks;
    logic [CNT_W-1:0]  send_ticks;
    tick_report_t      expected_reports[$];
    int                errors;

    initial begin
        fail_count    = 0;
        pending_count = 0;
        errors        = 0;
    end

    function automatic tick_report_t debounce_tick(input logic [MASK_W-1:0] pins);
        tick_report_t      rep;
        logic [MASK_W-1:0] active;
        logic [MASK_W-1:0] old_stable;
        logic [CNT_W-1:0]  since_send;
        int                k;
        active     = ~pins;
        old_stable = stable_now;
        if (active != last_active)
        begin
            last_active  = active;
            change_ticks = '0;
        end
        else if (change_ticks != CNT_MAX)
        begin
            change_ticks = change_ticks + 1'b1;
        end
        if (change_ticks > cfg.debounce_ticks)
        begin
            stable_now = active;
        end
        since_send  = (send_ticks == CNT_MAX) ? send_ticks : send_ticks + 1'b1;
        rep.send    = (stable_now != old_stable) || (since_send >= cfg.heartbeat_ticks);
        send_ticks  = rep.send ? '0 : since_send;
        rep.pressed = stable_now & ~old_stable;
        rep.stable  = stable_now;
        for (k = 0; k < MASK_W; k++)
        begin
            rep.payload[k] = stable_now[k] ? BYTE_W'(k + 2) : '0;
        end
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tick_report_t seen;
        tick_report_t want;
        if (!rst_n)
        begin
            cfg.debounce_ticks  = DEBOUNCE_RESET;
            cfg.heartbeat_ticks = HEARTBEAT_RESET;
            last_active         = '0;
            stable_now          = '0;
            change_ticks        = '0;
            send_ticks          = '0;
            expected_reports.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEBOUNCE:  cfg.debounce_ticks  = cfg_wdata;
                    REG_HEARTBEAT: cfg.heartbeat_ticks = cfg_wdata;
                    default:       ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                seen.send    = send_frame;
                seen.pressed = pressed_mask;
                seen.stable  = stable_mask;
                seen.payload = {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0};
                if (expected_reports.size() == 0)
                begin
                    if (errors < MAX_REPORTS)
                        $display("unexpected report: send=%0d pressed=%02h stable=%02h payload=%08h",
                                 seen.send, seen.pressed, seen.stable, seen.payload);
                    errors++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (seen !== want)
                    begin
                        if (errors < MAX_REPORTS)
                        begin
                            $display("mismatch: expected send=%0d pressed=%02h stable=%02h payload=%08h",
                                     want.send, want.pressed, want.stable, want.payload);
                            $display("          actual   send=%0d pressed=%02h stable=%02h payload=%08h",
                                     seen.send, seen.pressed, seen.stable, seen.payload);
                        end
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_reports.push_back(debounce_tick(pin_levels));
            end
        end
        fail_count    <= errors;
        pending_count <= expected_reports.size();
    end

endmodule

/* verif/tb_top.sv */
// Testbench top for switch_mask_debounce_reporter_top: clock, reset, config
// writes, sample and stall stimulus, final verdict. Depends on smdr_pkg,
// the block and smdr_checker.
`timescale 1ns / 1ps

module tb_top;

    import smdr_pkg::*;

    localparam logic [IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [IDX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SOAK_TICKS   = 40;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 40;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic [MASK_W-1:0]   pin_levels   = '1;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic                send_frame;
    logic [MASK_W-1:0]   pressed_mask;
    logic [MASK_W-1:0]   stable_mask;
    logic [BYTE_W-1:0]   byte0;
    logic [BYTE_W-1:0]   byte1;
    logic [BYTE_W-1:0]   byte2;
    logic [BYTE_W-1:0]   byte3;
    logic [BYTE_W-1:0]   byte4;
    logic [BYTE_W-1:0]   byte5;
    logic [BYTE_W-1:0]   byte6;
    logic [BYTE_W-1:0]   byte7;
    logic                cfg_we       = 1'b0;
    logic [IDX_W-1:0]    cfg_index    = '0;
    logic [CFG_W-1:0]    cfg_wdata    = '0;
    int                  fail_count;
    int                  pending_count;
    int                  cycle_count  = 0;
    bit                  gaps_on      = 1'b1;
    bit                  stall_on     = 1'b1;

    always #4 clk = ~clk;

    switch_mask_debounce_reporter_top i_dut (.*);

    smdr_checker i_checker (.*);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin : stall_gen
        int n;
        forever
        begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
            repeat (n) @(posedge clk);
            if (stall_on)
            begin
                out_stall <= 1'b1;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Present one sample and hold it until the block takes it.
    task automatic push_tick(input logic [MASK_W-1:0] pins);
        int r;
        int gap;
        gap = 0;
        if (gaps_on)
        begin
            r = $urandom_range(0, 99);
            if (r >= 95)
                gap = $urandom_range(10, 30);
            else if (r >= 70)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        pin_levels <= pins;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Drain all reports, then write one register.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [MASK_W-1:0] pins;
        logic [MASK_W-1:0] last_pins;
        logic [CFG_W-1:0]  deb_now;
        logic [CFG_W-1:0]  hb_now;
        int                issued;
        int                run;
        int                n;
        int                ph;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // first ticks after reset with the reset config
        push_tick(8'hFF);
        push_tick(8'hFF);

        // zero debounce, short heartbeat
        write_reg(REG_DEBOUNCE, 16'd0);
        write_reg(REG_HEARTBEAT, 16'd3);
        push_tick(8'h00);
        push_tick(8'h00);
        push_tick(8'hAA);
        push_tick(8'h55);
        push_tick(8'hFE);
        push_tick(8'h7F);
        push_tick(8'h7F);
        push_tick(8'hFF);
        push_tick(8'hFF);
        push_tick(8'hFF);
        push_tick(8'hFF);

        // heartbeat of zero sends every tick
        write_reg(REG_HEARTBEAT, 16'd0);
        write_reg(REG_DEBOUNCE, 16'd1);
        push_tick(8'hF0);
        push_tick(8'hF0);
        push_tick(8'hF0);
        push_tick(8'h0F);

        // unused indexes must be ignored
        write_reg(REG_SPARE_2, 16'hFFFF);
        write_reg(REG_SPARE_3, 16'h0000);
        write_reg(REG_HEARTBEAT, 16'hFFFF);
        push_tick(8'h3C);
        push_tick(8'h3C);
        push_tick(8'h3C);

        // hold a steady mask under the largest debounce values
        write_reg(REG_DEBOUNCE, 16'hFFFF);
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        repeat (SOAK_TICKS) push_tick(8'h5A);
        write_reg(REG_DEBOUNCE, 16'hFFFE);
        push_tick(8'h5A);
        push_tick(8'h5A);
        push_tick(8'h5A);

        last_pins = 8'h5A;
        for (ph = 0; ph < PHASES; ph++)
        begin
            case ($urandom_range(0, 7))
                0:       deb_now = 16'd0;
                1:       deb_now = 16'd1;
                2, 3, 4: deb_now = CFG_W'($urandom_range(2, 8));
                5:       deb_now = CFG_W'($urandom_range(9, 25));
                6:       deb_now = 16'hFFFF;
                default: deb_now = CFG_W'($urandom_range(100, 5000));
            endcase
            case ($urandom_range(0, 7))
                0:       hb_now = 16'd1;
                1:       hb_now = 16'd2;
                2, 3, 4: hb_now = CFG_W'($urandom_range(3, 30));
                5:       hb_now = 16'hFFFF;
                6:       hb_now = CFG_W'($urandom_range(31, 200));
                default: hb_now = ($urandom_range(0, 3) == 0) ? 16'd0
                                                             : CFG_W'($urandom_range(1, 10));
            endcase
            write_reg(REG_DEBOUNCE, deb_now);
            write_reg(REG_HEARTBEAT, hb_now);
            if ($urandom_range(0, 3) == 0)
                write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_2 : REG_SPARE_3,
                          CFG_W'($urandom));
            gaps_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);

            issued = 0;
            while (issued < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    if ($urandom_range(0, 2) == 0)
                        pins = last_pins ^ MASK_W'(1 << $urandom_range(0, MASK_W - 1));
                    else
                        pins = MASK_W'($urandom);
                    run = (deb_now <= 16'd40) ? int'(deb_now) + $urandom_range(1, 6)
                                              : $urandom_range(1, 10);
                    if ($urandom_range(0, 5) == 0 && run > 1)
                        run = $urandom_range(1, run - 1);
                    repeat (run) push_tick(pins);
                    issued += run;
                    last_pins = pins;
                end
                else
                begin
                    n = $urandom_range(1, 3);
                    repeat (n)
                    begin
                        pins = MASK_W'($urandom);
                        push_tick(pins);
                    end
                    issued += n;
                    last_pins = pins;
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
